/* rtl/btr_pkg.sv */
// Package with the types and constants shared by the block transfer receiver files.
package btr_pkg;

    localparam int NUM_WORDS = 8;
    localparam int LANE_BYTES = 8;
    localparam int LANE_SUM_W = 11;
    localparam int TOTAL_SUM_W = 14;

    localparam logic [15:0] END_MARK = 16'hFFFF;
    localparam logic [15:0] ERR_MARK = 16'hFFFE;

    localparam logic [1:0] CFG_BLOCK_COUNT = 2'd0;
    localparam logic [1:0] CFG_IMAGE_CRC = 2'd1;
    localparam logic [1:0] CFG_STORE_READY = 2'd2;

    typedef struct packed {
        logic [63:0]           word;
        logic [LANE_SUM_W-1:0] sum;
    } lane_res_t;

endpackage

/* rtl/btr_if.sv */
// Handshake interfaces for the packet, result and configuration channels.
interface btr_pkt_if;
    logic        valid;
    logic        ready;
    logic [15:0] block_number;
    logic [15:0] payload_length;
    logic [15:0] payload_sum;
    logic [63:0] payload_word_0;
    logic [63:0] payload_word_1;
    logic [63:0] payload_word_2;
    logic [63:0] payload_word_3;
    logic [63:0] payload_word_4;
    logic [63:0] payload_word_5;
    logic [63:0] payload_word_6;
    logic [63:0] payload_word_7;

    modport source (
        output valid, block_number, payload_length, payload_sum,
        output payload_word_0, payload_word_1, payload_word_2, payload_word_3,
        output payload_word_4, payload_word_5, payload_word_6, payload_word_7,
        input  ready
    );
    modport sink (
        input  valid, block_number, payload_length, payload_sum,
        input  payload_word_0, payload_word_1, payload_word_2, payload_word_3,
        input  payload_word_4, payload_word_5, payload_word_6, payload_word_7,
        output ready
    );
endinterface

interface btr_res_if;
    logic        valid;
    logic        ready;
    logic        send_reply;
    logic [15:0] reply_word;
    logic        store_block;
    logic [6:0]  store_length;
    logic [63:0] store_word_0;
    logic [63:0] store_word_1;
    logic [63:0] store_word_2;
    logic [63:0] store_word_3;
    logic [63:0] store_word_4;
    logic [63:0] store_word_5;
    logic [63:0] store_word_6;
    logic [63:0] store_word_7;

    modport source (
        output valid, send_reply, reply_word, store_block, store_length,
        output store_word_0, store_word_1, store_word_2, store_word_3,
        output store_word_4, store_word_5, store_word_6, store_word_7,
        input  ready
    );
    modport sink (
        input  valid, send_reply, reply_word, store_block, store_length,
        input  store_word_0, store_word_1, store_word_2, store_word_3,
        input  store_word_4, store_word_5, store_word_6, store_word_7,
        output ready
    );
endinterface

interface btr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/btr_lane.sv */
// One payload lane: masks eight bytes against the length and sums the kept bytes.
module btr_lane #(
    parameter int LANE_INDEX = 0
) (
    input  logic [63:0]       word,
    input  logic [15:0]       payload_length,
    output btr_pkg::lane_res_t res
);
    import btr_pkg::*;

    always_comb
    begin
        res.word = '0;
        res.sum = '0;
        for (int j = 0; j < LANE_BYTES; j++)
        begin
            if (payload_length > 16'(LANE_INDEX * LANE_BYTES + j))
            begin
                res.word[8*j +: 8] = word[8*j +: 8];
                res.sum = res.sum + LANE_SUM_W'(word[8*j +: 8]);
            end
        end
    end

endmodule

/* rtl/btr_merge.sv */
// Merging stage: adds the lane sums and checks them against the sender's checksum.
module btr_merge (
    input  btr_pkg::lane_res_t lanes [btr_pkg::NUM_WORDS],
    input  logic [15:0]        payload_sum,
    output logic               sum_ok
);
    import btr_pkg::*;

    logic [TOTAL_SUM_W-1:0] total;

    always_comb
    begin
        total = '0;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            total = total + TOTAL_SUM_W'(lanes[i].sum);
        end
        sum_ok = (16'(total) == payload_sum);
    end

endmodule

/* rtl/block_transfer_receiver_unit.sv */
// Top level of the block transfer receiver: lanes, merge, sequence control and result register.
// One packet transfer can be taken every cycle while results are taken as fast, and every
// accepted packet gives exactly one result transfer, registered in turn: the first
// register holds the masked lane words and per-lane byte sums, the second holds the result after
// the lane sums are merged, checked, and the block sequence state (expected block, closed
// storage, done) is updated. While a result waits, the pipeline holds, and packet ready drops
// once the first register is full as well. The sequence state lives only in the second stage,
// so consecutive packets see each other's updates in order. Configuration writes are taken at
// any time and must be made while idle.
module block_transfer_receiver_unit #(
    parameter int BLOCK_BYTES = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    btr_pkt_if.sink  pkt,
    btr_res_if.source result,
    btr_cfg_if.sink  cfg
);
    import btr_pkg::*;

    localparam int NUM_LANES = (BLOCK_BYTES + LANE_BYTES - 1) / LANE_BYTES;

    logic [63:0] pkt_word [NUM_WORDS];
    lane_res_t   lane_res [NUM_WORDS];

    logic [15:0] block_count_reg;
    logic [31:0] image_crc_reg;
    logic        store_ready_reg;

    logic [15:0] next_block_reg, next_block_next;
    logic        transfer_done_reg, transfer_done_next;
    logic        store_closed_reg, store_closed_next;

    logic        s1_valid_reg;
    logic [15:0] s1_blk_reg;
    logic [15:0] s1_len_reg;
    logic [15:0] s1_sum_reg;
    logic [31:0] s1_crc_reg;
    lane_res_t   s1_lane_reg [NUM_WORDS];

    logic        out_valid_reg;
    logic        send_reply_reg, send_reply_next;
    logic [15:0] reply_word_reg, reply_word_next;
    logic        store_block_reg, store_block_next;
    logic [6:0]  store_length_reg, store_length_next;
    logic [63:0] store_word_reg [NUM_WORDS];
    logic [63:0] store_word_next [NUM_WORDS];

    logic        sum_ok;
    logic        advance;
    logic        pkt_take;
    logic [15:0] next_block_inc;

    assign pkt_word[0] = pkt.payload_word_0;
    assign pkt_word[1] = pkt.payload_word_1;
    assign pkt_word[2] = pkt.payload_word_2;
    assign pkt_word[3] = pkt.payload_word_3;
    assign pkt_word[4] = pkt.payload_word_4;
    assign pkt_word[5] = pkt.payload_word_5;
    assign pkt_word[6] = pkt.payload_word_6;
    assign pkt_word[7] = pkt.payload_word_7;

    generate
        for (genvar g = 0; g < NUM_WORDS; g++)
        begin : g_lane
            if (g < NUM_LANES)
            begin : g_used
                btr_lane #(
                    .LANE_INDEX (g)
                ) u_lane (
                    .word           (pkt_word[g]),
                    .payload_length (pkt.payload_length),
                    .res            (lane_res[g])
                );
            end
            else
            begin : g_unused
                assign lane_res[g] = '0;
            end
        end
    endgenerate

    btr_merge u_merge (
        .lanes       (s1_lane_reg),
        .payload_sum (s1_sum_reg),
        .sum_ok      (sum_ok)
    );

    assign advance = s1_valid_reg && (!out_valid_reg || result.ready);
    assign pkt.ready = !s1_valid_reg || advance;
    assign pkt_take = pkt.valid && pkt.ready;
    assign cfg.ready = 1'b1;
    assign next_block_inc = next_block_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= 16'd1;
            image_crc_reg <= '0;
            store_ready_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_BLOCK_COUNT: block_count_reg <= cfg.data[15:0];
                CFG_IMAGE_CRC:   image_crc_reg <= cfg.data;
                CFG_STORE_READY: store_ready_reg <= cfg.data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pkt.ready)
        begin
            s1_valid_reg <= pkt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_take)
        begin
            s1_blk_reg <= pkt.block_number;
            s1_len_reg <= pkt.payload_length;
            s1_sum_reg <= pkt.payload_sum;
            s1_crc_reg <= pkt.payload_word_0[31:0];
            s1_lane_reg <= lane_res;
        end
    end

    always_comb
    begin
        send_reply_next = 1'b0;
        reply_word_next = '0;
        store_block_next = 1'b0;
        store_length_next = '0;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            store_word_next[i] = '0;
        end
        next_block_next = next_block_reg;
        transfer_done_next = transfer_done_reg;
        store_closed_next = store_closed_reg;

        if (transfer_done_reg)
        begin
            if (s1_blk_reg == END_MARK)
            begin
                send_reply_next = 1'b1;
                reply_word_next = END_MARK;
            end
        end
        else if (s1_blk_reg == END_MARK)
        begin
            send_reply_next = 1'b1;
            if (next_block_reg != block_count_reg)
            begin
                reply_word_next = ERR_MARK;
            end
            else if (s1_crc_reg == image_crc_reg)
            begin
                reply_word_next = END_MARK;
                transfer_done_next = 1'b1;
            end
            else
            begin
                reply_word_next = ERR_MARK;
            end
        end
        else if (s1_len_reg <= 16'(BLOCK_BYTES) && sum_ok)
        begin
            if (s1_blk_reg == next_block_reg)
            begin
                send_reply_next = 1'b1;
                reply_word_next = s1_blk_reg;
                if (store_ready_reg && !store_closed_reg)
                begin
                    store_block_next = 1'b1;
                    store_length_next = s1_len_reg[6:0];
                    for (int i = 0; i < NUM_WORDS; i++)
                    begin
                        store_word_next[i] = s1_lane_reg[i].word;
                    end
                    next_block_next = next_block_inc;
                    if (next_block_inc == block_count_reg)
                    begin
                        store_closed_next = 1'b1;
                    end
                end
            end
            else if (s1_blk_reg < next_block_reg)
            begin
                send_reply_next = 1'b1;
                reply_word_next = s1_blk_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_block_reg <= '0;
            transfer_done_reg <= 1'b0;
            store_closed_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                next_block_reg <= next_block_next;
                transfer_done_reg <= transfer_done_next;
                store_closed_reg <= store_closed_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            send_reply_reg <= send_reply_next;
            reply_word_reg <= reply_word_next;
            store_block_reg <= store_block_next;
            store_length_reg <= store_length_next;
            store_word_reg <= store_word_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.send_reply = send_reply_reg;
    assign result.reply_word = reply_word_reg;
    assign result.store_block = store_block_reg;
    assign result.store_length = store_length_reg;
    assign result.store_word_0 = store_word_reg[0];
    assign result.store_word_1 = store_word_reg[1];
    assign result.store_word_2 = store_word_reg[2];
    assign result.store_word_3 = store_word_reg[3];
    assign result.store_word_4 = store_word_reg[4];
    assign result.store_word_5 = store_word_reg[5];
    assign result.store_word_6 = store_word_reg[6];
    assign result.store_word_7 = store_word_reg[7];

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        transfer_done_reg |=> transfer_done_reg)
        else $error("Transfer done flag cleared without reset.");

    a_store_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && store_block_next) |=> (next_block_reg == $past(next_block_inc)))
        else $error("Stored block did not advance the expected block number.");

    a_store_acked: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.store_block) |->
            (result.send_reply && result.store_length <= 7'(BLOCK_BYTES)))
        else $error("Stored block without acknowledge or with bad length.");

endmodule

/* sim/block_transfer_receiver_unit_tb.sv */
// Self-checking testbench for the block transfer receiver with random stalls on both channels.
`timescale 1ns / 1ps

module block_transfer_receiver_unit_tb;
    import btr_pkg::*;

    localparam int BLOCK_BYTES = 64;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 290;

    typedef struct packed {
        logic [15:0]  number;
        logic [15:0]  length;
        logic [15:0]  sum;
        logic [511:0] data;
    } packet_t;

    typedef struct packed {
        logic         send;
        logic [15:0]  word;
        logic         store;
        logic [6:0]   length;
        logic [511:0] data;
    } outcome_t;

    logic clk;
    logic rst_n;

    btr_pkt_if pkt_ch ();
    btr_res_if res_ch ();
    btr_cfg_if cfg_ch ();

    block_transfer_receiver_unit #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_ch),
        .result(res_ch),
        .cfg   (cfg_ch)
    );

    packet_t  pkt_queue[$];
    outcome_t due_results[$];
    packet_t  on_wire;
    packet_t  next_pkt;
    logic     pkt_fired;
    logic     calm;
    int       send_gap;
    int       hold_gap;
    int       idle_cycles;
    int       mismatches;
    int       results_seen;
    int       packets_taken;
    int       blocks_stored;
    int       replies_due;
    int       reg_writes;

    // Mirror of the receiver: register settings and sequence state.
    logic [15:0] reg_count;
    logic [31:0] reg_crc;
    logic        reg_store_ready;
    logic [15:0] exp_next;
    logic        exp_done;
    logic        exp_closed;

    // Block number the stimulus generator treats as the next in-order block.
    logic [15:0] sender_next;

    function automatic logic [15:0] byte_sum(logic [511:0] bytes, logic [15:0] length);
        logic [15:0] total;
        total = '0;
        for (int i = 0; i < BLOCK_BYTES; i++)
            if (i < length)
                total += bytes[8*i +: 8];
        return total;
    endfunction

    function automatic outcome_t judge_packet(packet_t p);
        outcome_t o;
        o = '0;
        if (exp_done) begin
            if (p.number == END_MARK) begin
                o.send = 1'b1;
                o.word = END_MARK;
            end
            return o;
        end
        if (p.number == END_MARK) begin
            o.send = 1'b1;
            if (exp_next != reg_count)
                o.word = ERR_MARK;
            else if (p.data[31:0] == reg_crc) begin
                o.word = END_MARK;
                exp_done = 1'b1;
            end
            else
                o.word = ERR_MARK;
            return o;
        end
        if (p.length > BLOCK_BYTES)
            return o;
        if (byte_sum(p.data, p.length) != p.sum)
            return o;
        if (p.number == exp_next) begin
            if (reg_store_ready && !exp_closed) begin
                o.store = 1'b1;
                o.length = p.length[6:0];
                for (int i = 0; i < BLOCK_BYTES; i++)
                    if (i < p.length)
                        o.data[8*i +: 8] = p.data[8*i +: 8];
                exp_next = exp_next + 16'd1;
                if (exp_next == reg_count)
                    exp_closed = 1'b1;
            end
        end
        else if (p.number > exp_next)
            return o;
        o.send = 1'b1;
        o.word = p.number;
        return o;
    endfunction

    function automatic logic [511:0] random_bytes();
        logic [511:0] bytes;
        for (int k = 0; k < 16; k++)
            bytes[32*k +: 32] = $urandom;
        return bytes;
    endfunction

    function automatic logic [15:0] pick_length();
        case ($urandom_range(0, 3))
            0: return 16'd64;
            1: return 16'($urandom_range(0, 8));
            default: return 16'($urandom_range(0, 64));
        endcase
    endfunction

    function automatic packet_t make_block(logic [15:0] number, logic [15:0] length,
                                           logic [511:0] bytes, bit sum_ok);
        packet_t p;
        p.number = number;
        p.length = length;
        p.data = bytes;
        p.sum = byte_sum(bytes, length);
        if (!sum_ok)
            p.sum ^= 16'($urandom_range(1, 65535));
        return p;
    endfunction

    function automatic packet_t make_end(bit crc_hit);
        packet_t p;
        p.number = END_MARK;
        p.length = 16'($urandom);
        p.sum = 16'($urandom);
        p.data = random_bytes();
        if (crc_hit)
            p.data[31:0] = reg_crc;
        return p;
    endfunction

    function automatic packet_t random_packet();
        packet_t p;
        int r;
        r = $urandom_range(0, 99);
        if (r < 60 || (r < 68 && sender_next == 0)) begin
            p = make_block(sender_next, pick_length(), random_bytes(), 1'b1);
            if (reg_store_ready)
                sender_next = sender_next + 16'd1;
        end
        else if (r < 68)
            p = make_block(16'($urandom_range(0, int'(sender_next) - 1)), pick_length(),
                           random_bytes(), 1'b1);
        else if (r < 73)
            p = make_block(16'($urandom_range(int'(sender_next) + 1, 65534)), pick_length(),
                           random_bytes(), 1'b1);
        else if (r < 78)
            p = make_block(sender_next, pick_length(), random_bytes(), 1'b0);
        else if (r < 83)
            p = make_block(sender_next, 16'($urandom_range(65, 65535)), random_bytes(), 1'b1);
        else if (r < 88)
            p = make_end($urandom_range(0, 1) == 1);
        else begin
            p.number = 16'($urandom);
            p.length = 16'($urandom);
            p.sum = 16'($urandom);
            p.data = random_bytes();
        end
        return p;
    endfunction

    function automatic bit field_diff(string name, logic [63:0] want, logic [63:0] got);
        if (want === got)
            return 1'b0;
        if (mismatches < 10)
            $display("Mismatch at result %0d, %s: expected %h, got %h",
                     results_seen, name, want, got);
        return 1'b1;
    endfunction

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (index)
            CFG_BLOCK_COUNT: reg_count = value[15:0];
            CFG_IMAGE_CRC:   reg_crc = value;
            CFG_STORE_READY: reg_store_ready = value[0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        while (pkt_queue.size() != 0 || pkt_ch.valid || due_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(int count);
        sender_next = exp_next;
        repeat (count) pkt_queue.push_back(random_packet());
        settle();
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        if (!rst_n)
            pkt_ch.valid <= 1'b0;
        else if (!pkt_ch.valid || pkt_fired) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                pkt_ch.valid <= 1'b0;
            end
            else if (pkt_queue.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 9);
                pkt_ch.valid <= 1'b0;
            end
            else if (pkt_queue.size() != 0) begin
                next_pkt = pkt_queue.pop_front();
                on_wire <= next_pkt;
                pkt_ch.block_number <= next_pkt.number;
                pkt_ch.payload_length <= next_pkt.length;
                pkt_ch.payload_sum <= next_pkt.sum;
                pkt_ch.payload_word_0 <= next_pkt.data[63:0];
                pkt_ch.payload_word_1 <= next_pkt.data[127:64];
                pkt_ch.payload_word_2 <= next_pkt.data[191:128];
                pkt_ch.payload_word_3 <= next_pkt.data[255:192];
                pkt_ch.payload_word_4 <= next_pkt.data[319:256];
                pkt_ch.payload_word_5 <= next_pkt.data[383:320];
                pkt_ch.payload_word_6 <= next_pkt.data[447:384];
                pkt_ch.payload_word_7 <= next_pkt.data[511:448];
                pkt_ch.valid <= 1'b1;
            end
            else
                pkt_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk) begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_gap != 0) begin
            hold_gap <= hold_gap - 1;
            res_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0) begin
            hold_gap <= $urandom_range(0, 9);
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    always @(posedge clk) begin : watch_results
        outcome_t seen;
        outcome_t want;
        outcome_t fresh;
        bit       bad;
        if (rst_n) begin
            pkt_fired <= pkt_ch.valid && pkt_ch.ready;
            if (pkt_ch.valid && pkt_ch.ready) begin
                fresh = judge_packet(on_wire);
                due_results.push_back(fresh);
                packets_taken++;
                if (fresh.store)
                    blocks_stored++;
                if (fresh.send)
                    replies_due++;
            end
            if (res_ch.valid && res_ch.ready) begin
                seen.send = res_ch.send_reply;
                seen.word = res_ch.reply_word;
                seen.store = res_ch.store_block;
                seen.length = res_ch.store_length;
                seen.data = {res_ch.store_word_7, res_ch.store_word_6, res_ch.store_word_5,
                             res_ch.store_word_4, res_ch.store_word_3, res_ch.store_word_2,
                             res_ch.store_word_1, res_ch.store_word_0};
                if (due_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("Unexpected result %0d: reply %b %h, store %b length %0d",
                                 results_seen, seen.send, seen.word, seen.store, seen.length);
                    mismatches++;
                end
                else begin
                    want = due_results.pop_front();
                    bad = field_diff("send_reply", 64'(want.send), 64'(seen.send));
                    bad |= field_diff("reply_word", 64'(want.word), 64'(seen.word));
                    bad |= field_diff("store_block", 64'(want.store), 64'(seen.store));
                    bad |= field_diff("store_length", 64'(want.length), 64'(seen.length));
                    for (int k = 0; k < 8; k++)
                        bad |= field_diff($sformatf("store_word_%0d", k),
                                          want.data[64*k +: 64], seen.data[64*k +: 64]);
                    if (bad)
                        mismatches++;
                end
                results_seen++;
            end
            if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT) begin
                $display("No transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, due_results.size());
                $display("block_transfer_receiver_unit_tb NOT OK");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        rst_n = 1'b0;
        calm = 1'b0;
        pkt_fired = 1'b0;
        send_gap = 0;
        hold_gap = 0;
        idle_cycles = 0;
        mismatches = 0;
        results_seen = 0;
        packets_taken = 0;
        blocks_stored = 0;
        replies_due = 0;
        reg_writes = 0;
        reg_count = 16'd1;
        reg_crc = '0;
        reg_store_ready = 1'b1;
        exp_next = '0;
        exp_done = 1'b0;
        exp_closed = 1'b0;
        sender_next = '0;
        on_wire = '0;
        next_pkt = '0;
        pkt_ch.valid = 1'b0;
        pkt_ch.block_number = '0;
        pkt_ch.payload_length = '0;
        pkt_ch.payload_sum = '0;
        pkt_ch.payload_word_0 = '0;
        pkt_ch.payload_word_1 = '0;
        pkt_ch.payload_word_2 = '0;
        pkt_ch.payload_word_3 = '0;
        pkt_ch.payload_word_4 = '0;
        pkt_ch.payload_word_5 = '0;
        pkt_ch.payload_word_6 = '0;
        pkt_ch.payload_word_7 = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register values from reset: only packets that neither store nor finish.
        pkt_queue.push_back(make_end(1'b1));
        pkt_queue.push_back(make_block(16'd3, 16'd10, random_bytes(), 1'b1));
        pkt_queue.push_back(make_block(16'd0, 16'd65, random_bytes(), 1'b1));
        pkt_queue.push_back(make_block(16'd0, 16'hFFFF, '1, 1'b1));
        pkt_queue.push_back(make_block(16'd0, 16'd64, random_bytes(), 1'b0));
        pkt_queue.push_back(make_block(16'hFFFE, 16'd5, random_bytes(), 1'b1));
        settle();

        write_reg(CFG_BLOCK_COUNT, 32'd65534);
        write_reg(CFG_IMAGE_CRC, 32'hFFFF_FFFF);
        write_reg(CFG_STORE_READY, 32'd0);
        pkt_queue.push_back(make_block(16'd0, 16'd64, random_bytes(), 1'b1));
        pkt_queue.push_back(make_end(1'b1));
        settle();

        write_reg(CFG_STORE_READY, 32'd1);
        pkt_queue.push_back(make_block(16'd0, 16'd64, '1, 1'b1));
        pkt_queue.push_back(make_block(16'd1, 16'd64, '0, 1'b1));
        pkt_queue.push_back(make_block(16'd2, 16'd0, random_bytes(), 1'b1));
        pkt_queue.push_back(make_block(16'd3, 16'd1, '1, 1'b1));
        pkt_queue.push_back(make_block(16'd4, 16'd7, random_bytes(), 1'b1));
        pkt_queue.push_back(make_block(16'd5, 16'd8, random_bytes(), 1'b1));
        pkt_queue.push_back(make_block(16'd6, 16'd9, random_bytes(), 1'b1));
        pkt_queue.push_back(make_block(16'd7, 16'd63, '1, 1'b1));
        pkt_queue.push_back(make_block(16'd2, 16'd12, random_bytes(), 1'b1));
        pkt_queue.push_back(make_block(16'd0, 16'd30, random_bytes(), 1'b0));
        pkt_queue.push_back(make_block(16'd20, 16'd16, random_bytes(), 1'b1));
        pkt_queue.push_back(make_block(16'd8, 16'd0, random_bytes(), 1'b0));
        pkt_queue.push_back(make_end(1'b0));
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            calm = (ph == 3);
            if (ph == 1)
                write_reg(CFG_BLOCK_COUNT, 32'd1);
            else if (ph == 4)
                write_reg(CFG_BLOCK_COUNT, 32'd65534);
            else
                write_reg(CFG_BLOCK_COUNT, $urandom_range(int'(exp_next) + 400, 65534));
            if (ph == 0)
                write_reg(CFG_IMAGE_CRC, 32'd0);
            else if (ph == 2)
                write_reg(CFG_IMAGE_CRC, 32'hFFFF_FFFF);
            else
                write_reg(CFG_IMAGE_CRC, $urandom);
            write_reg(CFG_STORE_READY, (ph == 2) ? 32'd0 : 32'd1);
            run_phase(PHASE_ITEMS);
        end

        // Close the image, finish it, then keep sending with no stalls at all.
        calm = 1'b1;
        sender_next = exp_next;
        write_reg(CFG_BLOCK_COUNT, 32'(exp_next) + 32'd4);
        write_reg(CFG_IMAGE_CRC, $urandom);
        write_reg(CFG_STORE_READY, 32'd1);
        pkt_queue.push_back(make_block(sender_next, pick_length(), random_bytes(), 1'b1));
        pkt_queue.push_back(make_block(sender_next + 16'd1, 16'd20, random_bytes(), 1'b0));
        pkt_queue.push_back(make_block(sender_next + 16'd1, 16'd64, random_bytes(), 1'b1));
        pkt_queue.push_back(make_end(1'b1));
        pkt_queue.push_back(make_block(sender_next + 16'd2, pick_length(), random_bytes(), 1'b1));
        pkt_queue.push_back(make_block(sender_next + 16'd3, 16'd33, random_bytes(), 1'b1));
        pkt_queue.push_back(make_block(sender_next + 16'd4, 16'd64, random_bytes(), 1'b1));
        pkt_queue.push_back(make_end(1'b0));
        pkt_queue.push_back(make_end(1'b1));
        pkt_queue.push_back(make_block(sender_next + 16'd2, 16'd8, random_bytes(), 1'b1));
        pkt_queue.push_back(make_end(1'b0));
        settle();
        run_phase(60);

        $display("Covered %0d packets: %0d blocks stored, %0d replies, %0d register writes.",
                 packets_taken, blocks_stored, replies_due, reg_writes);
        $display("Transfer done: %0d, results checked: %0d, mismatches: %0d.",
                 exp_done, results_seen, mismatches);
        if (mismatches == 0 && due_results.size() == 0)
            $display("block_transfer_receiver_unit_tb OK");
        else
            $display("block_transfer_receiver_unit_tb NOT OK");
        $finish;
    end

endmodule
